FILE: src/vfcm_pkg.sv
package vfcm_pkg;

   // chunk edge in voxels
   localparam int EDGE = 16;

   localparam int VOX_W = 4;
   localparam int CIDX_W = (EDGE > 1) ? $clog2(EDGE) : 1;
   localparam int ROWS = EDGE * EDGE;
   localparam int ROW_W = $clog2(ROWS);
   localparam int POS_W = 16;
   localparam int COLOR_W = 4;
   localparam int CHUNK_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_FACES = 6;
   localparam int VERTS_PER_FACE = 6;
   localparam int FACE_W = 3;
   localparam int VERT_W = 3;
   localparam int STEP_W = 3;
   localparam int NUM_READS = 5;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_Z = CSR_IDX_W'(2);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_FILL = 2'd1;
   localparam logic [1:0] MODE_MESH = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_FILL,
      CMD_MESH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [VOX_W-1:0] x;
      logic [VOX_W-1:0] y;
      logic [VOX_W-1:0] z;
      logic solid;
   } cmd_type;

   typedef struct packed {
      logic signed [CHUNK_W-1:0] chunk_x;
      logic signed [CHUNK_W-1:0] chunk_y;
      logic signed [CHUNK_W-1:0] chunk_z;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WB,
      ST_FILL,
      ST_MESH_RD,
      ST_EMIT
   } back_state_type;

   // corner index per face vertex, faces in +Z -Z -X +X +Y -Y order
   localparam logic [2:0] FACE_CORNER [NUM_FACES][VERTS_PER_FACE] = '{
      '{4, 6, 5, 4, 7, 6},
      '{0, 1, 2, 0, 2, 3},
      '{0, 3, 7, 0, 7, 4},
      '{1, 5, 6, 1, 6, 2},
      '{3, 2, 6, 3, 6, 7},
      '{0, 4, 5, 0, 5, 1}
   };

   localparam logic FACE_U [NUM_FACES][VERTS_PER_FACE] = '{
      '{0, 1, 1, 0, 0, 1},
      '{0, 1, 1, 0, 1, 0},
      '{0, 0, 1, 0, 1, 1},
      '{0, 1, 1, 0, 1, 0},
      '{0, 1, 1, 0, 1, 0},
      '{0, 0, 1, 0, 1, 1}
   };

   localparam logic FACE_V [NUM_FACES][VERTS_PER_FACE] = '{
      '{0, 1, 0, 0, 1, 1},
      '{0, 0, 1, 0, 1, 1},
      '{0, 1, 1, 0, 1, 0},
      '{0, 0, 1, 0, 1, 1},
      '{0, 0, 1, 0, 1, 1},
      '{0, 1, 1, 0, 1, 0}
   };

   localparam logic CORNER_X [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
   localparam logic CORNER_Y [8] = '{0, 0, 1, 1, 0, 0, 1, 1};
   localparam logic CORNER_Z [8] = '{0, 0, 0, 0, 1, 1, 1, 1};

   // voxel index over edge as a four-bit fraction, saturated
   function automatic logic [15:0][COLOR_W-1:0] build_frac_lut();
      logic [15:0][COLOR_W-1:0] lut;
      int f;
      for (int v = 0; v < 16; v++) begin
         f = (v * 16) / EDGE;
         lut[v] = (f > 15) ? COLOR_W'(15) : COLOR_W'(f);
      end
      return lut;
   endfunction

   localparam logic [15:0][COLOR_W-1:0] FRAC_LUT = build_frac_lut();

endpackage

FILE: src/vfcm_ram.sv
module vfcm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/vfcm_front.sv
module vfcm_front import vfcm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [VOX_W-1:0] req_voxel_x,
   input  logic [VOX_W-1:0] req_voxel_y,
   input  logic [VOX_W-1:0] req_voxel_z,
   input  logic             req_solid,
   input  back_status_type  status,
   output logic             q_push,
   output cmd_type          q_data,
   input  logic             q_full
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   cmd_type cls_cmd;
   logic    cls_keep;
   logic    in_chunk;
   logic    accept;

   assign in_chunk = (int'(req_voxel_x) < EDGE) && (int'(req_voxel_y) < EDGE)
                     && (int'(req_voxel_z) < EDGE);

   // sort the request; out-of-chunk writes, bad meshes and the spare mode vanish here
   always_comb begin
      cls_cmd.x = req_voxel_x;
      cls_cmd.y = req_voxel_y;
      cls_cmd.z = req_voxel_z;
      cls_cmd.solid = req_solid;
      cls_cmd.kind = CMD_WRITE;
      cls_keep = 1'b0;
      case (req_mode)
         MODE_WRITE: begin
            cls_cmd.kind = CMD_WRITE;
            cls_keep = in_chunk;
         end
         MODE_FILL: begin
            cls_cmd.kind = CMD_FILL;
            cls_keep = 1'b1;
         end
         MODE_MESH: begin
            cls_cmd.kind = CMD_MESH;
            cls_keep = in_chunk;
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   assign req_full = status.clearing || (hold_valid_ff && q_full);
   assign accept = req_push && !req_full;
   assign q_push = hold_valid_ff && !q_full;
   assign q_data = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = cls_keep;
         hold_cmd_in = cls_cmd;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

FILE: src/vfcm_queue.sv
module vfcm_queue import vfcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type data_in,
   output logic    full,
   input  logic    pop,
   output cmd_type data_out,
   output logic    empty
);

   cmd_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full = (int'(count_ff) == QDEPTH);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: src/vfcm_back.sv
module vfcm_back import vfcm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      q_empty,
   input  cmd_type                   q_data,
   output logic                      q_pop,
   output back_status_type           status,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic signed [POS_W-1:0]   rsp_pos_z,
   output logic [COLOR_W-1:0]        rsp_color_red,
   output logic [COLOR_W-1:0]        rsp_color_green,
   output logic [COLOR_W-1:0]        rsp_color_blue,
   output logic                      rsp_tex_u,
   output logic                      rsp_tex_v,
   output logic [FACE_W-1:0]         rsp_face_id,
   output logic                      rsp_last
);

   function automatic logic [ROW_W-1:0] row_addr(input int x, input int y);
      return ROW_W'(x * EDGE + y);
   endfunction

   back_state_type       state_ff, state_in;
   logic [ROW_W-1:0]     cnt_ff, cnt_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 solid_ff, solid_in;
   logic [NUM_FACES-1:0] mask_ff, mask_in;
   logic [VERT_W-1:0]    vert_ff, vert_in;
   logic [POS_W-1:0]     base_x_ff, base_x_in;
   logic [POS_W-1:0]     base_y_ff, base_y_in;
   logic [POS_W-1:0]     base_z_ff, base_z_in;
   logic [COLOR_W-1:0]   col_r_ff, col_r_in;
   logic [COLOR_W-1:0]   col_g_ff, col_g_in;
   logic [COLOR_W-1:0]   col_b_ff, col_b_in;

   logic                 out_valid_ff, out_valid_in;
   logic [POS_W-1:0]     out_pos_x_ff, out_pos_y_ff, out_pos_z_ff;
   logic [COLOR_W-1:0]   out_r_ff, out_g_ff, out_b_ff;
   logic                 out_u_ff, out_v_ff, out_last_ff;
   logic [FACE_W-1:0]    out_face_ff;

   logic [ROW_W-1:0]     ram_addr;
   logic                 ram_we;
   logic [EDGE-1:0]      ram_wdata, ram_rdata;

   logic                 x_first, x_last, y_first, y_last, z_first, z_last;
   logic [ROW_W-1:0]     center_addr, step_addr;
   logic [CIDX_W-1:0]    z_idx, zp_idx, zm_idx;
   logic [FACE_W-1:0]    cur_face;
   logic [NUM_FACES-1:0] rest_mask;
   logic [2:0]           corner;
   logic                 out_free, emit, emit_last;

   vfcm_ram #(
      .WIDTH(EDGE),
      .DEPTH(ROWS)
   ) u_occ (
      .clock(clock),
      .addr (ram_addr),
      .we   (ram_we),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign x_first = (cmd_ff.x == '0);
   assign y_first = (cmd_ff.y == '0);
   assign z_first = (cmd_ff.z == '0);
   assign x_last = (int'(cmd_ff.x) == EDGE - 1);
   assign y_last = (int'(cmd_ff.y) == EDGE - 1);
   assign z_last = (int'(cmd_ff.z) == EDGE - 1);

   assign center_addr = row_addr(int'(cmd_ff.x), int'(cmd_ff.y));
   assign z_idx = CIDX_W'(int'(cmd_ff.z));
   assign zp_idx = CIDX_W'(z_last ? int'(cmd_ff.z) : int'(cmd_ff.z) + 1);
   assign zm_idx = CIDX_W'(z_first ? int'(cmd_ff.z) : int'(cmd_ff.z) - 1);

   // row reads: center, x-1, x+1, y-1, y+1; rows off the chunk reread the center
   always_comb begin
      case (step_ff)
         STEP_W'(1): step_addr = x_first ? center_addr
                                 : row_addr(int'(cmd_ff.x) - 1, int'(cmd_ff.y));
         STEP_W'(2): step_addr = x_last ? center_addr
                                 : row_addr(int'(cmd_ff.x) + 1, int'(cmd_ff.y));
         STEP_W'(3): step_addr = y_first ? center_addr
                                 : row_addr(int'(cmd_ff.x), int'(cmd_ff.y) - 1);
         STEP_W'(4): step_addr = y_last ? center_addr
                                 : row_addr(int'(cmd_ff.x), int'(cmd_ff.y) + 1);
         default: step_addr = center_addr;
      endcase
   end

   always_comb begin
      cur_face = '0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_face = FACE_W'(i);
         end
      end
   end

   assign rest_mask = mask_ff & ~(NUM_FACES'(1) << cur_face);
   assign corner = FACE_CORNER[cur_face][vert_ff];
   assign out_free = !out_valid_ff || rsp_pop;
   assign emit = (state_ff == ST_EMIT) && solid_ff && (mask_ff != '0) && out_free;
   assign emit_last = (int'(vert_ff) == VERTS_PER_FACE - 1) && (rest_mask == '0);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      cmd_in = cmd_ff;
      solid_in = solid_ff;
      mask_in = mask_ff;
      vert_in = vert_ff;
      base_x_in = base_x_ff;
      base_y_in = base_y_ff;
      base_z_in = base_z_ff;
      col_r_in = col_r_ff;
      col_g_in = col_g_ff;
      col_b_in = col_b_ff;
      q_pop = 1'b0;
      ram_addr = center_addr;
      ram_we = 1'b0;
      ram_wdata = ram_rdata;
      case (state_ff)
         ST_CLEAR: begin
            ram_addr = cnt_ff;
            ram_we = 1'b1;
            ram_wdata = '0;
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == ROWS - 1) begin
               cnt_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_data;
               case (q_data.kind)
                  CMD_WRITE: state_in = ST_WR_RD;
                  CMD_FILL: begin
                     cnt_in = '0;
                     state_in = ST_FILL;
                  end
                  CMD_MESH: begin
                     step_in = '0;
                     mask_in = '0;
                     vert_in = '0;
                     solid_in = 1'b0;
                     base_x_in = POS_W'(int'(cfg.chunk_x) * EDGE + int'(q_data.x));
                     base_y_in = POS_W'(int'(cfg.chunk_y) * EDGE + int'(q_data.y));
                     base_z_in = POS_W'(int'(cfg.chunk_z) * EDGE + int'(q_data.z));
                     col_r_in = FRAC_LUT[q_data.x];
                     col_g_in = FRAC_LUT[q_data.y];
                     col_b_in = FRAC_LUT[q_data.z];
                     state_in = ST_MESH_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WR_RD: begin
            state_in = ST_WR_WB;
         end
         ST_WR_WB: begin
            ram_we = 1'b1;
            ram_wdata[z_idx] = cmd_ff.solid;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            ram_addr = cnt_ff;
            ram_we = 1'b1;
            ram_wdata = {EDGE{cmd_ff.solid}};
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == ROWS - 1) begin
               cnt_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_MESH_RD: begin
            ram_addr = step_addr;
            step_in = step_ff + 1'b1;
            // read data comes back in the cycle after its address
            case (step_ff)
               STEP_W'(1): begin
                  solid_in = ram_rdata[z_idx];
                  mask_in[0] = z_last || !ram_rdata[zp_idx];
                  mask_in[1] = z_first || !ram_rdata[zm_idx];
               end
               STEP_W'(2): mask_in[2] = x_first || !ram_rdata[z_idx];
               STEP_W'(3): mask_in[3] = x_last || !ram_rdata[z_idx];
               STEP_W'(4): mask_in[5] = y_first || !ram_rdata[z_idx];
               STEP_W'(5): begin
                  mask_in[4] = y_last || !ram_rdata[z_idx];
                  state_in = ST_EMIT;
               end
               default: begin
               end
            endcase
         end
         ST_EMIT: begin
            if (!solid_ff || mask_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               vert_in = vert_ff + 1'b1;
               if (int'(vert_ff) == VERTS_PER_FACE - 1) begin
                  vert_in = '0;
                  mask_in = rest_mask;
                  if (rest_mask == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         step_ff <= '0;
         mask_ff <= '0;
         vert_ff <= '0;
         solid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         step_ff <= step_in;
         mask_ff <= mask_in;
         vert_ff <= vert_in;
         solid_ff <= solid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      base_x_ff <= base_x_in;
      base_y_ff <= base_y_in;
      base_z_ff <= base_z_in;
      col_r_ff <= col_r_in;
      col_g_ff <= col_g_in;
      col_b_ff <= col_b_in;
      if (emit) begin
         out_pos_x_ff <= base_x_ff + POS_W'(CORNER_X[corner]);
         out_pos_y_ff <= base_y_ff + POS_W'(CORNER_Y[corner]);
         out_pos_z_ff <= base_z_ff + POS_W'(CORNER_Z[corner]);
         out_r_ff <= col_r_ff;
         out_g_ff <= col_g_ff;
         out_b_ff <= col_b_ff;
         out_u_ff <= FACE_U[cur_face][vert_ff];
         out_v_ff <= FACE_V[cur_face][vert_ff];
         out_face_ff <= cur_face;
         out_last_ff <= emit_last;
      end
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_empty = !out_valid_ff;
   assign rsp_pos_x = out_pos_x_ff;
   assign rsp_pos_y = out_pos_y_ff;
   assign rsp_pos_z = out_pos_z_ff;
   assign rsp_color_red = out_r_ff;
   assign rsp_color_green = out_g_ff;
   assign rsp_color_blue = out_b_ff;
   assign rsp_tex_u = out_u_ff;
   assign rsp_tex_v = out_v_ff;
   assign rsp_face_id = out_face_ff;
   assign rsp_last = out_last_ff;

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !q_pop)
      else $error("command taken during clearing pass");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_FILL || state_ff == ST_WR_WB))
      else $error("occupancy written outside a write state");

   a_last_ends_mesh: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (state_ff == ST_IDLE))
      else $error("mesh did not end after its last vertex");

   a_emit_solid: assert property (@(posedge clock) disable iff (reset)
      emit |-> (solid_ff && int'(vert_ff) < VERTS_PER_FACE))
      else $error("vertex emitted for empty voxel or bad corner count");

endmodule

FILE: src/voxel_face_culling_mesher_unit.sv
// channel   direction  handshake            payload
// req       in         req_push / req_full  mode, voxel_x/y/z, solid
// rsp       out        rsp_empty / rsp_pop  pos_x/y/z, color rgb, tex_u/v, face_id, last
// csr       in         csr_we               csr_index, csr_wdata (chunk_x, chunk_y, chunk_z)
//
// a write request reads its row and then writes it back; a fill writes all EDGE*EDGE rows, one row per cycle
// a mesh request reads its rows, then emits one vertex per cycle (up to 36) while the output register is free
// the single-port occupancy row memory and the one-vertex output register set these rates
// after reset a clearing pass over all EDGE*EDGE rows (256) holds req_full high
// rsp_pop low stalls vertex generation; the front keeps taking requests until its queue and hold register fill
module voxel_face_culling_mesher_unit import vfcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [1:0]               req_mode,
   input  logic [VOX_W-1:0]         req_voxel_x,
   input  logic [VOX_W-1:0]         req_voxel_y,
   input  logic [VOX_W-1:0]         req_voxel_z,
   input  logic                     req_solid,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic signed [POS_W-1:0]  rsp_pos_z,
   output logic [COLOR_W-1:0]       rsp_color_red,
   output logic [COLOR_W-1:0]       rsp_color_green,
   output logic [COLOR_W-1:0]       rsp_color_blue,
   output logic                     rsp_tex_u,
   output logic                     rsp_tex_v,
   output logic [FACE_W-1:0]        rsp_face_id,
   output logic                     rsp_last,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CHUNK_W-1:0]       csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   back_status_type status;
   logic            q_push, q_full, q_pop, q_empty;
   cmd_type         q_wdata, q_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_X: cfg_in.chunk_x = csr_wdata;
            CSR_CHUNK_Y: cfg_in.chunk_y = csr_wdata;
            CSR_CHUNK_Z: cfg_in.chunk_z = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vfcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_voxel_x(req_voxel_x),
      .req_voxel_y(req_voxel_y),
      .req_voxel_z(req_voxel_z),
      .req_solid  (req_solid),
      .status     (status),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .q_full     (q_full)
   );

   vfcm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .data_in (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .data_out(q_rdata),
      .empty   (q_empty)
   );

   vfcm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .status         (status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_pos_z      (rsp_pos_z),
      .rsp_color_red  (rsp_color_red),
      .rsp_color_green(rsp_color_green),
      .rsp_color_blue (rsp_color_blue),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_face_id    (rsp_face_id),
      .rsp_last       (rsp_last)
   );

endmodule
